>>> hdl/qkvs_pkg.sv
// Shared widths, register codes, target codes and the derived-configuration
// bundle of the QKV splitter with key/value cache writer. No dependencies.
package qkvs_pkg;

  // Item field widths
  localparam int SAMPLE_W   = 6;
  localparam int POS_W      = 17;
  localparam int ELEM_W     = 16;
  localparam int DATA_W     = 32;
  localparam int BF16_W     = 16;
  localparam int ADDR_W     = 48;
  localparam int TARGET_W   = 2;

  // Configuration register widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int HS_W       = 9;
  localparam int QH_W       = 8;
  localparam int KVH_W      = 7;
  localparam int SEQ_W      = 18;
  localparam int LAYER_W    = 7;
  localparam int CAP_W      = 7;
  localparam int WIN_W      = 18;
  localparam int BCNT_W     = 7;

  // Derived quantity widths
  localparam int KVDIM_W    = HS_W + KVH_W;          // head_size * kv_heads
  localparam int QLEN_W     = HS_W + QH_W;           // head_size * query_heads
  localparam int TOTAL_W    = QLEN_W + 1;            // q_len + 2 * kv_dim
  localparam int CAPX_W     = CAP_W + SEQ_W;         // capacity * rows
  localparam int LSTRIDE_W  = CAPX_W + KVDIM_W;      // one layer's size
  localparam int LHALF_W    = LAYER_W;               // (layer + 1) / 2
  localparam int QADDR_W    = SAMPLE_W + QLEN_W + 1; // sample * q_len + elem
  localparam int ROW_W      = SAMPLE_W + SEQ_W + 1;  // sample * stride + pos
  localparam int ROWKV_W    = ROW_W + KVDIM_W;       // row * kv_dim

  // Remainder pipeline: position mod window, a few quotient bits per stage
  localparam int REM_W        = WIN_W;
  localparam int REM_STEP     = 3;
  localparam int REM_STAGES   = (POS_W + REM_STEP - 1) / REM_STEP;
  localparam int REM_STAGE_W  = $clog2(REM_STAGES);
  localparam int POS_IDX_W    = $clog2(POS_W);

  // Register reset values
  localparam logic [HS_W-1:0]    HS_RST   = HS_W'(64);
  localparam logic [QH_W-1:0]    QH_RST   = QH_W'(64);
  localparam logic [KVH_W-1:0]   KVH_RST  = KVH_W'(8);
  localparam logic [SEQ_W-1:0]   SEQ_RST  = SEQ_W'(4096);
  localparam logic [LAYER_W-1:0] LAYER_RST = LAYER_W'(0);
  localparam logic [CAP_W-1:0]   CAP_RST  = CAP_W'(8);
  localparam logic [WIN_W-1:0]   WIN_RST  = WIN_W'(128);
  localparam logic [BCNT_W-1:0]  BCNT_RST = BCNT_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD_SIZE       = 3'd0,
    REG_QUERY_HEADS     = 3'd1,
    REG_KV_HEADS        = 3'd2,
    REG_SEQUENCE_LENGTH = 3'd3,
    REG_LAYER_NUMBER    = 3'd4,
    REG_BATCH_CAPACITY  = 3'd5,
    REG_WINDOW_SIZE     = 3'd6,
    REG_BATCH_COUNT     = 3'd7
  } cfg_reg_e;

  typedef enum logic [TARGET_W-1:0] {
    TGT_QUERY = 2'd0,
    TGT_KEY   = 2'd1,
    TGT_VALUE = 2'd2
  } target_e;

  // Configuration as the item pipeline sees it. Each member lags the last write
  // by the register depth noted beside it (raw members are the registers themselves).
  typedef struct packed {
    logic [WIN_W-1:0]   win;          // raw
    logic [BCNT_W-1:0]  batch_count;  // raw
    logic [KVDIM_W-1:0] kv_dim;       // depth 1
    logic [QLEN_W-1:0]  q_len;        // depth 1
    logic [SEQ_W-1:0]   stride;       // depth 1
    logic               odd;          // depth 1
    logic [TOTAL_W-1:0] total;        // depth 2
    logic [ADDR_W-1:0]  base;         // depth 4
  } cfg_t;

endpackage

>>> hdl/qkvs_cfg.sv
// Configuration registers and the pipelined products derived from them
// (row sizes, layer strides, layer base). Depends on qkvs_pkg.
module qkvs_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [qkvs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [qkvs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output qkvs_pkg::cfg_t                  cfg_o
);
  import qkvs_pkg::*;

  logic [HS_W-1:0]    hs_q;
  logic [QH_W-1:0]    qh_q;
  logic [KVH_W-1:0]   kvh_q;
  logic [SEQ_W-1:0]   seq_q;
  logic [LAYER_W-1:0] layer_q;
  logic [CAP_W-1:0]   cap_q;
  logic [WIN_W-1:0]   win_q;
  logic [BCNT_W-1:0]  bcnt_q;

  // depth 1
  logic [KVDIM_W-1:0] kv_dim_q;
  logic [QLEN_W-1:0]  q_len_q;
  logic [CAPX_W-1:0]  cap_seq_q, cap_win_q;
  logic [LHALF_W-1:0] lh_q, lh1_q;
  logic [SEQ_W-1:0]   stride_q;
  logic               odd_q;
  // depth 2
  logic [TOTAL_W-1:0]   total_q;
  logic [LSTRIDE_W-1:0] l_odd_q, l_even_q;
  // depth 3
  logic [ADDR_W-1:0]    part_odd_q, part_even_q;
  // depth 4
  logic [ADDR_W-1:0]    base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q    <= HS_RST;
      qh_q    <= QH_RST;
      kvh_q   <= KVH_RST;
      seq_q   <= SEQ_RST;
      layer_q <= LAYER_RST;
      cap_q   <= CAP_RST;
      win_q   <= WIN_RST;
      bcnt_q  <= BCNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_HEAD_SIZE:       hs_q    <= cfg_data_i[HS_W-1:0];
        REG_QUERY_HEADS:     qh_q    <= cfg_data_i[QH_W-1:0];
        REG_KV_HEADS:        kvh_q   <= cfg_data_i[KVH_W-1:0];
        REG_SEQUENCE_LENGTH: seq_q   <= cfg_data_i[SEQ_W-1:0];
        REG_LAYER_NUMBER:    layer_q <= cfg_data_i[LAYER_W-1:0];
        REG_BATCH_CAPACITY:  cap_q   <= cfg_data_i[CAP_W-1:0];
        REG_WINDOW_SIZE:     win_q   <= cfg_data_i[WIN_W-1:0];
        REG_BATCH_COUNT:     bcnt_q  <= cfg_data_i[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Free-running product chain: registered multiplies, then the final base add.
  always_ff @(posedge clk_i) begin
    kv_dim_q  <= KVDIM_W'(hs_q) * KVDIM_W'(kvh_q);
    q_len_q   <= QLEN_W'(hs_q) * QLEN_W'(qh_q);
    cap_seq_q <= CAPX_W'(cap_q) * CAPX_W'(seq_q);
    cap_win_q <= CAPX_W'(cap_q) * CAPX_W'(win_q);
    lh_q      <= LHALF_W'(layer_q >> 1);
    lh1_q     <= LHALF_W'(({1'b0, layer_q} + (LAYER_W + 1)'(1)) >> 1);
    stride_q  <= layer_q[0] ? seq_q : win_q;
    odd_q     <= layer_q[0];

    total_q   <= TOTAL_W'(q_len_q) + TOTAL_W'({kv_dim_q, 1'b0});
    l_odd_q   <= LSTRIDE_W'(cap_seq_q) * LSTRIDE_W'(kv_dim_q);
    l_even_q  <= LSTRIDE_W'(cap_win_q) * LSTRIDE_W'(kv_dim_q);

    part_odd_q  <= ADDR_W'(lh_q) * ADDR_W'(l_odd_q);
    part_even_q <= ADDR_W'(lh1_q) * ADDR_W'(l_even_q);

    base_q <= part_odd_q + part_even_q;
  end

  assign cfg_o.win         = win_q;
  assign cfg_o.batch_count = bcnt_q;
  assign cfg_o.kv_dim      = kv_dim_q;
  assign cfg_o.q_len       = q_len_q;
  assign cfg_o.stride      = stride_q;
  assign cfg_o.odd         = odd_q;
  assign cfg_o.total       = total_q;
  assign cfg_o.base        = base_q;

endmodule

>>> hdl/qkvs_rem_step.sv
// One stage of the restoring remainder unit that reduces a cache position
// modulo the window size, a few quotient bits per stage. Depends on qkvs_pkg.
module qkvs_rem_step (
  input  logic [qkvs_pkg::REM_STAGE_W-1:0] stage_i,
  input  logic [qkvs_pkg::WIN_W-1:0]       win_i,
  input  logic [qkvs_pkg::POS_W-1:0]       pos_i,
  input  logic [qkvs_pkg::REM_W-1:0]       rem_i,
  output logic [qkvs_pkg::REM_W-1:0]       rem_o
);
  import qkvs_pkg::*;

  always_comb begin
    logic [REM_W:0]   acc;
    logic [REM_W-1:0] rem;
    int               idx;
    rem = rem_i;
    acc = '0;
    for (int j = 0; j < REM_STEP; j++) begin
      idx = POS_W - 1 - REM_STEP * int'(stage_i) - j;
      if (idx >= 0) begin
        // Shift in the next dividend bit, subtract the divisor if it fits.
        acc = {rem, pos_i[idx[POS_IDX_W-1:0]]};
        if (acc >= {1'b0, win_i}) begin
          acc = acc - {1'b0, win_i};
        end
        rem = acc[REM_W-1:0];
      end
    end
    rem_o = rem;
  end

endmodule

>>> hdl/qkv_split_kv_cache_writer.sv
// Top level of the QKV splitter with key/value cache writer: item pipeline,
// bfloat16 rounding and address assembly. Depends on qkvs_pkg, qkvs_cfg and
// qkvs_rem_step.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one element of a fused
//   query-key-value row: sample, cache position, element index, fp32 bits.
//   Output channel (out_valid_o / out_ready_i) carries target buffer, element
//   address and data (fp32 for query, bfloat16 in the low half otherwise).
//   Items for unused samples or past the end of the row are dropped inside.
//   Configuration goes through cfg_we_i / cfg_index_i / cfg_data_i, one
//   register per write, only while no item is in flight.
// Timing:
//   The input register feeds six stages of the position-mod-window remainder
//   unit (up to three quotient bits each), then row multiply, row-times-kv_dim
//   multiply and final add.
//   One item per cycle while out_ready_i is high. Every stage has its own valid
//   bit and takes a new item whenever it is empty or its successor moves, so
//   bubbles collapse and a stalled receiver only blocks once the pipe is full.
// Reset:
//   rst_ni clears all valid bits and loads the register defaults; derived
//   layer strides are not reset and settle after reset or a write via qkvs_cfg.
module qkv_split_kv_cache_writer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [qkvs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [qkvs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [qkvs_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic [qkvs_pkg::POS_W-1:0]      position_i,
  input  logic [qkvs_pkg::ELEM_W-1:0]     element_index_i,
  input  logic [qkvs_pkg::DATA_W-1:0]     value_bits_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [qkvs_pkg::TARGET_W-1:0]   target_o,
  output logic [qkvs_pkg::ADDR_W-1:0]     address_o,
  output logic [qkvs_pkg::DATA_W-1:0]     data_o
);
  import qkvs_pkg::*;

  // Stage map: logic of stage k sits between register k and register k+1.
  localparam int SEL_ST  = 1;               // query/kv split, query row base
  localparam int KEEP_ST = 2;               // drop check, key/value split
  localparam int ROW_ST  = REM_STAGES;      // cache row
  localparam int MUL_ST  = REM_STAGES + 1;  // row * kv_dim
  localparam int ADD_ST  = REM_STAGES + 2;  // final address
  localparam int NUM_ST  = REM_STAGES + 4;  // registers including output

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]    pos;
    logic [ELEM_W-1:0]   elem;
    logic [DATA_W-1:0]   bits;
    logic [BF16_W-1:0]   bf;
    logic                is_q;
    logic                keep;
    logic [ELEM_W-1:0]   off;
    logic [QADDR_W-1:0]  qaddr;
    logic [REM_W-1:0]    rem;
    logic [ROW_W-1:0]    row;
    logic [ROWKV_W-1:0]  rowkv;
    target_e             target;
    logic [ADDR_W-1:0]   addr;
  } pipe_t;

  cfg_t  cfg;
  pipe_t st_q  [NUM_ST];
  pipe_t nxt   [NUM_ST];
  logic  v_q   [NUM_ST];
  logic  v_in  [NUM_ST];
  logic  rdy   [NUM_ST];
  logic [REM_W-1:0] rem_out [REM_STAGES];

  // Round to nearest even; NaN keeps sign and top mantissa bits, made quiet.
  function automatic logic [BF16_W-1:0] to_bf16(input logic [DATA_W-1:0] f);
    logic [DATA_W:0] r;
    if (f[30:23] == 8'hFF && f[22:0] != 23'd0) begin
      return f[31:16] | 16'h0040;
    end
    r = {1'b0, f} + (DATA_W + 1)'(16'h7FFF) + (DATA_W + 1)'(f[16]);
    return r[31:16];
  endfunction

  qkvs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Remainder unit: one step per pipeline stage, fed from that stage's register.
  for (genvar s = 0; s < REM_STAGES; s++) begin : g_rem
    qkvs_rem_step u_rem_step (
      .stage_i (REM_STAGE_W'(s)),
      .win_i   (cfg.win),
      .pos_i   (st_q[s].pos),
      .rem_i   (st_q[s].rem),
      .rem_o   (rem_out[s])
    );
  end

  // Handshake: a stage may load when empty or when its successor moves.
  always_comb begin
    rdy[NUM_ST-1] = !v_q[NUM_ST-1] || out_ready_i;
    for (int k = NUM_ST - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end
  assign in_ready_o = rdy[0];

  // Stage datapath.
  always_comb begin
    pipe_t cur;
    nxt[0]        = '0;
    nxt[0].sample = sample_i;
    nxt[0].pos    = position_i;
    nxt[0].elem   = element_index_i;
    nxt[0].bits   = value_bits_i;
    nxt[0].target = TGT_QUERY;
    v_in[0]       = in_valid_i;
    for (int k = 1; k < NUM_ST; k++) begin
      cur = st_q[k-1];
      if (k - 1 < REM_STAGES) begin
        cur.rem = rem_out[k-1];
      end
      case (k - 1)
        0: begin
          cur.bf = to_bf16(cur.bits);
        end
        SEL_ST: begin
          cur.is_q  = {1'b0, cur.elem} < cfg.q_len;
          cur.off   = ELEM_W'({1'b0, cur.elem} - cfg.q_len);
          cur.qaddr = QADDR_W'(cur.sample) * QADDR_W'(cfg.q_len);
          if (!cur.is_q) begin
            cur.bits = {{(DATA_W - BF16_W){1'b0}}, cur.bf};
          end
        end
        KEEP_ST: begin
          cur.keep  = (BCNT_W'(cur.sample) < cfg.batch_count) &&
                      (TOTAL_W'(cur.elem) < cfg.total);
          cur.qaddr = cur.qaddr + QADDR_W'(cur.elem);
          if (cur.is_q) begin
            cur.target = TGT_QUERY;
          end else if (KVDIM_W'(cur.off) < cfg.kv_dim) begin
            cur.target = TGT_KEY;
          end else begin
            cur.target = TGT_VALUE;
            cur.off    = cur.off - ELEM_W'(cfg.kv_dim);
          end
        end
        ROW_ST: begin
          // Odd layers use the raw position; even layers the wrapped one
          // (with a zero window the remainder equals the position).
          cur.row = ROW_W'(cur.sample) * ROW_W'(cfg.stride) +
                    ROW_W'(cfg.odd ? REM_W'(cur.pos) : cur.rem);
        end
        MUL_ST: begin
          cur.rowkv = ROWKV_W'(cur.row) * ROWKV_W'(cfg.kv_dim);
        end
        ADD_ST: begin
          if (cur.is_q) begin
            cur.addr = ADDR_W'(cur.qaddr);
          end else begin
            cur.addr = cfg.base + ADDR_W'(cur.rowkv) + ADDR_W'(cur.off);
          end
        end
        default: ;
      endcase
      nxt[k]  = cur;
      // Drop items for unused samples or past the row end.
      v_in[k] = v_q[k-1] && ((k - 1 != KEEP_ST) || cur.keep);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_ST; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < NUM_ST; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_ST; k++) begin
      if (rdy[k] && v_in[k]) begin
        st_q[k] <= nxt[k];
      end
    end
  end

  assign out_valid_o = v_q[NUM_ST-1];
  assign target_o    = st_q[NUM_ST-1].target;
  assign address_o   = st_q[NUM_ST-1].addr;
  assign data_o      = st_q[NUM_ST-1].bits;

  // An empty output register lets the whole pipe advance.
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output register is empty");

  // An accepted item always lands in the input stage.
  a_accept_loads_stage0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_q[0])
    else $error("accepted item not captured");

  // Only the three defined targets leave the block.
  a_target_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (target_o == TGT_QUERY || target_o == TGT_KEY ||
                     target_o == TGT_VALUE))
    else $error("undefined target code on output");

  // Cache data is bfloat16 with a zero upper half.
  a_cache_data_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && target_o != TGT_QUERY) |-> (data_o[31:16] == 16'd0))
    else $error("cache write data has nonzero upper half");

endmodule
